// ===== hdl/pcm2st_pkg.sv =====
package pcm2st_pkg;

  localparam int SAMPLE_W = 32;
  localparam int OUT_W    = 16;
  localparam int NUM_W    = 36;
  localparam int X_W      = 17;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [2:0] FMT_INT16_IL = 3'd0;
  localparam logic [2:0] FMT_INT16_PL = 3'd1;
  localparam logic [2:0] FMT_FLOAT_PL = 3'd2;
  localparam logic [2:0] FMT_INT32_IL = 3'd3;
  localparam logic [2:0] FMT_INT32_PL = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;

  localparam logic [2:0] FORMAT_RST   = FMT_INT16_IL;
  localparam logic [3:0] CHANNELS_RST = 4'd2;

  localparam logic [1:0] DEN_1  = 2'd0;
  localparam logic [1:0] DEN_6  = 2'd1;
  localparam logic [1:0] DEN_12 = 2'd2;

  // full scale per divisor, Q7.28
  localparam logic signed [NUM_W-1:0] LIM_D1  = 36'sh010000000;
  localparam logic signed [NUM_W-1:0] LIM_D6  = 36'sh060000000;
  localparam logic signed [NUM_W-1:0] LIM_D12 = 36'sh0C0000000;

  localparam logic signed [OUT_W-1:0] FULL_SCALE = 16'sh7FFF;

  // ceil(2^19 / 3): exact floor(x / 3) for x below 2^19
  localparam logic [17:0] RECIP3       = 18'd174763;
  localparam int          RECIP3_SHIFT = 19;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] chan0_sample;
    logic signed [SAMPLE_W-1:0] chan1_sample;
    logic signed [SAMPLE_W-1:0] chan2_sample;
    logic signed [SAMPLE_W-1:0] chan3_sample;
    logic signed [SAMPLE_W-1:0] chan4_sample;
    logic signed [SAMPLE_W-1:0] chan5_sample;
    logic                       frame_last_in;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;
    logic                    fault;
    logic                    frame_last_out;
  } out_t;

endpackage

// ===== hdl/pcm_frame_to_stereo_s16.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  pcm2st_pkg::in_t  (six samples, last mark)
// out_     output     out_valid/out_stall pcm2st_pkg::out_t (stereo pair, fault, last)
// cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// One item per cycle unless out_stall holds the output; an item passes the stage 1 and 2 registers to out_r.
// Stage 1 forms the downmix sums, stage 2 clamps and scales by 32767,
// stage 3 divides by three through a reciprocal multiply for divisors 6 and 12 and drives out_data.
// rst_n is synchronous; it empties the pipeline and restores the registers.
// A stall holds each full stage; in_stall rises only when all three are full.
module pcm_frame_to_stereo_s16 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pcm2st_pkg::in_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pcm2st_pkg::out_t                    out_data,
  input  logic                                cfg_we,
  input  logic [pcm2st_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcm2st_pkg::CFG_W-1:0]        cfg_wdata
);

  typedef struct packed {
    logic                 sat_pos;
    logic                 sat_neg;
    logic                 neg;
    logic [pcm2st_pkg::X_W-1:0] x;
  } scl_t;

  logic [2:0] sample_format_r;
  logic [3:0] channel_count_r;

  // stage 1
  logic                                    s1_v_r;
  logic                                    s1_fault_r, s1_float_r, s1_last_r;
  logic [1:0]                              s1_den_r;
  logic signed [pcm2st_pkg::NUM_W-1:0]     s1_num_l_r, s1_num_r_r;
  logic signed [pcm2st_pkg::OUT_W-1:0]     s1_int_l_r, s1_int_r_r;

  // stage 2
  logic                                    s2_v_r;
  logic                                    s2_fault_r, s2_float_r, s2_last_r;
  logic [1:0]                              s2_den_r;
  scl_t                                    s2_l_r, s2_r_r;
  logic signed [pcm2st_pkg::OUT_W-1:0]     s2_int_l_r, s2_int_r_r;

  // stage 3
  logic                                    out_v_r;
  pcm2st_pkg::out_t                        out_r;

  logic adv1, adv2, adv3;

  logic                                    s1_fault_nxt, s1_float_nxt;
  logic [1:0]                              s1_den_nxt;
  logic signed [pcm2st_pkg::NUM_W-1:0]     s1_num_l_nxt, s1_num_r_nxt;
  logic signed [pcm2st_pkg::OUT_W-1:0]     s1_int_l_nxt, s1_int_r_nxt;
  logic signed [pcm2st_pkg::NUM_W-1:0]     c0, c1, c2, c3, c4, c5, common;

  scl_t                                    s2_l_nxt, s2_r_nxt;
  logic signed [pcm2st_pkg::OUT_W-1:0]     fl_l, fl_r;
  pcm2st_pkg::out_t                        out_nxt;

  assign adv3      = !out_v_r || !out_stall;
  assign adv2      = !s2_v_r || adv3;
  assign adv1      = !s1_v_r || adv2;
  assign in_stall  = !adv1;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_format_r <= pcm2st_pkg::FORMAT_RST;
      channel_count_r <= pcm2st_pkg::CHANNELS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pcm2st_pkg::REG_FORMAT:   sample_format_r <= cfg_wdata[2:0];
        pcm2st_pkg::REG_CHANNELS: channel_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: select and sum
  always_comb begin
    c0 = pcm2st_pkg::NUM_W'(in_data.chan0_sample);
    c1 = pcm2st_pkg::NUM_W'(in_data.chan1_sample);
    c2 = pcm2st_pkg::NUM_W'(in_data.chan2_sample);
    c3 = pcm2st_pkg::NUM_W'(in_data.chan3_sample);
    c4 = pcm2st_pkg::NUM_W'(in_data.chan4_sample);
    c5 = pcm2st_pkg::NUM_W'(in_data.chan5_sample);
    common = (c2 <<< 1) + (c3 <<< 1);

    s1_fault_nxt = 1'b0;
    s1_float_nxt = 1'b0;
    s1_den_nxt   = pcm2st_pkg::DEN_1;
    s1_num_l_nxt = c0;
    s1_num_r_nxt = c1;
    s1_int_l_nxt = in_data.chan0_sample[15:0];
    s1_int_r_nxt = in_data.chan1_sample[15:0];

    case (sample_format_r)
      pcm2st_pkg::FMT_INT16_IL: begin
        s1_fault_nxt = channel_count_r < 4'd2;
      end
      pcm2st_pkg::FMT_INT16_PL: begin
        s1_fault_nxt = channel_count_r == 4'd0;
        if (channel_count_r == 4'd1) begin
          s1_int_r_nxt = in_data.chan0_sample[15:0];
        end else if (channel_count_r > 4'd2) begin
          s1_int_r_nxt = in_data.chan2_sample[15:0];
        end
      end
      pcm2st_pkg::FMT_FLOAT_PL: begin
        s1_fault_nxt = channel_count_r == 4'd0;
        s1_float_nxt = 1'b1;
        case (channel_count_r)
          4'd1: begin
            s1_num_r_nxt = c0;
          end
          4'd3: begin
            s1_den_nxt   = pcm2st_pkg::DEN_6;
            s1_num_l_nxt = (c0 <<< 2) + c0 + c2;
            s1_num_r_nxt = (c1 <<< 2) + c1 + c2;
          end
          4'd6: begin
            s1_den_nxt   = pcm2st_pkg::DEN_12;
            s1_num_l_nxt = (c0 <<< 3) - c0 + common + c4;
            s1_num_r_nxt = (c1 <<< 3) - c1 + common + c5;
          end
          default: ;
        endcase
      end
      pcm2st_pkg::FMT_INT32_IL: begin
        s1_fault_nxt = channel_count_r < 4'd2;
        s1_int_l_nxt = in_data.chan0_sample[31:16];
        s1_int_r_nxt = in_data.chan1_sample[31:16];
      end
      pcm2st_pkg::FMT_INT32_PL: begin
        s1_fault_nxt = channel_count_r == 4'd0;
        s1_int_l_nxt = in_data.chan0_sample[31:16];
        if (channel_count_r == 4'd1) begin
          s1_int_r_nxt = in_data.chan0_sample[31:16];
        end else if (channel_count_r == 4'd2) begin
          s1_int_r_nxt = in_data.chan1_sample[31:16];
        end else begin
          s1_int_r_nxt = in_data.chan2_sample[31:16];
        end
      end
      default: begin
        s1_fault_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_fault_r <= s1_fault_nxt;
      s1_float_r <= s1_float_nxt;
      s1_last_r  <= in_data.frame_last_in;
      s1_den_r   <= s1_den_nxt;
      s1_num_l_r <= s1_num_l_nxt;
      s1_num_r_r <= s1_num_r_nxt;
      s1_int_l_r <= s1_int_l_nxt;
      s1_int_r_r <= s1_int_r_nxt;
    end
  end

  // ---------------- stage 2: clamp, |num| * 32767, drop the power of two
  function automatic scl_t scale(input logic signed [pcm2st_pkg::NUM_W-1:0] num,
                                 input logic [1:0] den);
    logic signed [pcm2st_pkg::NUM_W-1:0] lim;
    logic [pcm2st_pkg::NUM_W-1:0]        mag;
    logic [46:0]                         p;
    scl_t                                s;
    case (den)
      pcm2st_pkg::DEN_6:  lim = pcm2st_pkg::LIM_D6;
      pcm2st_pkg::DEN_12: lim = pcm2st_pkg::LIM_D12;
      default:            lim = pcm2st_pkg::LIM_D1;
    endcase
    s.sat_pos = num > lim;
    s.sat_neg = num < -lim;
    s.neg     = num[pcm2st_pkg::NUM_W-1];
    mag       = s.neg ? pcm2st_pkg::NUM_W'(-num) : pcm2st_pkg::NUM_W'(num);
    p         = ({15'd0, mag[31:0]} << 15) - {15'd0, mag[31:0]};
    case (den)
      pcm2st_pkg::DEN_6:  s.x = p[29 +: pcm2st_pkg::X_W];
      pcm2st_pkg::DEN_12: s.x = p[30 +: pcm2st_pkg::X_W];
      default:            s.x = p[28 +: pcm2st_pkg::X_W];
    endcase
    return s;
  endfunction

  assign s2_l_nxt = scale(s1_num_l_r, s1_den_r);
  assign s2_r_nxt = scale(s1_num_r_r, s1_den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      s2_fault_r <= s1_fault_r;
      s2_float_r <= s1_float_r;
      s2_last_r  <= s1_last_r;
      s2_den_r   <= s1_den_r;
      s2_l_r     <= s2_l_nxt;
      s2_r_r     <= s2_r_nxt;
      s2_int_l_r <= s1_int_l_r;
      s2_int_r_r <= s1_int_r_r;
    end
  end

  // ---------------- stage 3: divide by three, sign, clamp, select
  function automatic logic signed [pcm2st_pkg::OUT_W-1:0] finish(input scl_t s,
                                                                 input logic [1:0] den);
    logic [34:0]                         prod;
    logic [pcm2st_pkg::OUT_W-1:0]        q;
    logic signed [pcm2st_pkg::OUT_W-1:0] v;
    prod = {18'd0, s.x} * {17'd0, pcm2st_pkg::RECIP3};
    q    = (den == pcm2st_pkg::DEN_1) ? s.x[pcm2st_pkg::OUT_W-1:0]
                                      : prod[pcm2st_pkg::RECIP3_SHIFT +: pcm2st_pkg::OUT_W];
    if (s.sat_pos) begin
      v = pcm2st_pkg::FULL_SCALE;
    end else if (s.sat_neg) begin
      v = -pcm2st_pkg::FULL_SCALE;
    end else if (s.neg) begin
      v = -q;
    end else begin
      v = q;
    end
    return v;
  endfunction

  assign fl_l = finish(s2_l_r, s2_den_r);
  assign fl_r = finish(s2_r_r, s2_den_r);

  always_comb begin
    out_nxt.fault          = s2_fault_r;
    out_nxt.frame_last_out = s2_last_r;
    if (s2_fault_r) begin
      out_nxt.left_out  = '0;
      out_nxt.right_out = '0;
    end else if (s2_float_r) begin
      out_nxt.left_out  = fl_l;
      out_nxt.right_out = fl_r;
    end else begin
      out_nxt.left_out  = s2_int_l_r;
      out_nxt.right_out = s2_int_r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv3) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_v_r) begin
      out_r <= out_nxt;
    end
  end

  // ---------------- checks
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault |-> out_data.left_out == '0 && out_data.right_out == '0)
    else $error("faulted item carries nonzero samples");

  a_float_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_float_r |-> fl_l != 16'sh8000 && fl_r != 16'sh8000)
    else $error("float path beyond full scale");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && s2_v_r && out_v_r)
    else $error("input stalled with a free stage");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && out_v_r && out_stall |=> s2_v_r && out_v_r)
    else $error("item dropped under stall");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !s1_v_r && !s2_v_r)
    else $error("pipeline not empty after reset");

endmodule
